### rtl/ptd_pkg.sv
// ---------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the priority task dispatcher
// Holds the command codes, task status codes, the control bundle that is
// broadcast to the task cells, and the reset priority table.
// ---------------------------------------------------------------------------
package ptd_pkg;

  // Default table size and number of priority levels.
  localparam int NUM_TASKS_DEF  = 5;
  localparam int NUM_LEVELS_DEF = 5;

  // Field widths.
  localparam int LEVEL_W  = 3;
  localparam int TIME_W   = 32;
  localparam int SCHEME_W = 12;
  localparam int TASK_W   = 3;

  // Number of tasks that take a priority from a packed scheme.
  localparam int SCHEME_TASKS = 4;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_DISPATCH = 2'd0,
    CMD_SLEEP    = 2'd1,
    CMD_HALT     = 2'd2,
    CMD_ROTATE   = 2'd3
  } cmd_t;

  // Task status codes.
  typedef enum logic [1:0] {
    TS_RUNNING  = 2'd0,
    TS_READY    = 2'd1,
    TS_SLEEPING = 2'd2,
    TS_HALTED   = 2'd3
  } task_status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCHEME_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SCHEME_SECOND = 2'd1;
  localparam logic [1:0] CFG_SCHEME_THIRD  = 2'd2;

  // Scheme numbers.
  localparam logic [1:0] SCHEME_ONE   = 2'd1;
  localparam logic [1:0] SCHEME_TWO   = 2'd2;
  localparam logic [1:0] SCHEME_THREE = 2'd3;

  // Reset values of the scheme registers.
  localparam logic [SCHEME_W-1:0] SCHEME_FIRST_RST  = 12'd2842;
  localparam logic [SCHEME_W-1:0] SCHEME_SECOND_RST = 12'd1701;
  localparam logic [SCHEME_W-1:0] SCHEME_THIRD_RST  = 12'd1170;

  // Control bundle broadcast to every task cell.
  typedef struct packed {
    logic                scan;
    logic                sleep;
    logic                halt;
    logic                rotate;
    logic [LEVEL_W-1:0]  level;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   period;
    logic [SCHEME_W-1:0] scheme;
  } ptd_ctrl_t;

  // Priority level of a task after reset.
  function automatic logic [LEVEL_W-1:0] level_init(input int idx);
    logic [LEVEL_W-1:0] lvl;
    case (idx)
      0:       lvl = 3'd2;
      1:       lvl = 3'd3;
      2:       lvl = 3'd4;
      3:       lvl = 3'd5;
      default: lvl = 3'd1;
    endcase
    return lvl;
  endfunction

endpackage

### rtl/ptd_cell.sv
// ---------------------------------------------------------------------------
// ptd_cell: one task entry of the dispatcher
// Holds the status, level, sleep timing and restart flag of one task. During
// a scan cycle it takes the search token from its lower neighbor, wakes or
// claims itself, and passes the token on.
// ---------------------------------------------------------------------------
module ptd_cell #(
  parameter int IDX  = 0,
  parameter bit LAST = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  ptd_pkg::ptd_ctrl_t  ctrl,
  input  logic                sel,
  input  logic                search_in,
  output logic                search_out,
  output logic                found,
  output logic                restart_flag
);
  import ptd_pkg::*;

  localparam bit TAKES_SCHEME = (IDX < SCHEME_TASKS);
  localparam int FIELD_LSB    = TAKES_SCHEME ? (LEVEL_W * IDX) : 0;

  task_status_t        status;
  logic [LEVEL_W-1:0]  level;
  logic [TIME_W-1:0]   sleep_start;
  logic [TIME_W-1:0]   sleep_length;
  logic                restart_q;

  logic                visit;
  logic                is_ready;
  logic                due;
  logic [TIME_W-1:0]   elapsed;

  // This cell is visited when the scan is at its level and no lower task
  // has been claimed at this level yet.
  always_comb begin
    elapsed    = ctrl.now - sleep_start;
    due        = (elapsed >= sleep_length);
    is_ready   = (status == TS_READY);
    visit      = ctrl.scan && (level == ctrl.level) && search_in;
    found      = visit && is_ready;
    search_out = search_in && !((ctrl.scan && (level == ctrl.level)) && is_ready);
  end

  assign restart_flag = restart_q;

  // Task state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      status       <= TS_READY;
      level        <= level_init(IDX);
      sleep_start  <= '0;
      sleep_length <= '0;
      restart_q    <= 1'b0;
    end else begin
      if (found) begin
        status <= TS_RUNNING;
      end else if (visit && (status == TS_SLEEPING) && due) begin
        status <= TS_READY;
      end else if (ctrl.sleep && sel) begin
        status       <= TS_SLEEPING;
        sleep_start  <= ctrl.now;
        sleep_length <= ctrl.period;
        restart_q    <= 1'b0;
      end else if (ctrl.halt && sel) begin
        status    <= TS_HALTED;
        restart_q <= 1'b0;
      end else if (ctrl.rotate && !LAST) begin
        status    <= TS_READY;
        restart_q <= 1'b1;
        if (TAKES_SCHEME) begin
          level <= ctrl.scheme[FIELD_LSB +: LEVEL_W];
        end
      end
    end
  end

endmodule

### rtl/priority_task_dispatcher_core.sv
// ---------------------------------------------------------------------------
// priority_task_dispatcher_core: non-preemptive priority task dispatcher
// Keeps a small task table and answers dispatch, sleep, halt and rotate
// commands with one result transaction each.
// ---------------------------------------------------------------------------
// The task table is a row of cells, one per task. A dispatch command scans
// one priority level per clock, from level 1 upward; within a level a search
// token ripples through the cells in index order, so the lowest ready task
// at the lowest level is dispatched, and sleeping tasks that were visited
// before it wake if their period has elapsed. The scan stops at the level
// at which a ready task is found, or at level NUM_LEVELS when none is;
// sleep, halt and rotate go straight from acceptance to the result stage.
// One command is worked on at a time; the result sits in an output register,
// so the next command is accepted while it waits.
module priority_task_dispatcher_core #(
  parameter int NUM_TASKS  = ptd_pkg::NUM_TASKS_DEF,
  parameter int NUM_LEVELS = ptd_pkg::NUM_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [71:0]                   s_tdata,   // cmd[1:0], now[33:2], period[65:34]
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // dispatched[0], task_res[3:1],
                                                   // restart[4], scheme_applied[6:5]
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ptd_pkg::SCHEME_W-1:0]  cfg_data
);
  import ptd_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;

  logic [SCHEME_W-1:0] scheme_first;
  logic [SCHEME_W-1:0] scheme_second;
  logic [SCHEME_W-1:0] scheme_third;
  logic [1:0]          scheme_number;
  logic [IDX_W-1:0]    current_index;
  logic [LEVEL_W-1:0]  scan_level;
  logic [TIME_W-1:0]   now_q;

  logic                res_disp;
  logic [TASK_W-1:0]   res_task;
  logic                res_restart;
  logic [1:0]          res_applied;

  logic                accept;
  cmd_t                in_cmd;
  logic [TIME_W-1:0]   in_now;
  logic [TIME_W-1:0]   in_period;
  logic [SCHEME_W-1:0] scheme_sel;
  logic                scan_done;
  logic                any_found;
  logic [TASK_W-1:0]   found_task;
  logic                found_restart;

  ptd_ctrl_t           ctrl;
  logic [NUM_TASKS-1:0] sel_vec;
  logic [NUM_TASKS:0]   token;
  logic [NUM_TASKS-1:0] found_vec;
  logic [NUM_TASKS-1:0] restart_vec;

  // Input field unpacking and handshake.
  assign in_cmd    = cmd_t'(s_tdata[1:0]);
  assign in_now    = s_tdata[33:2];
  assign in_period = s_tdata[65:34];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Scheme selected by the current scheme number.
  always_comb begin
    case (scheme_number)
      SCHEME_ONE: scheme_sel = scheme_first;
      SCHEME_TWO: scheme_sel = scheme_second;
      default:    scheme_sel = scheme_third;
    endcase
  end

  // Control bundle for the task cells.
  always_comb begin
    ctrl.scan   = (state == ST_SCAN);
    ctrl.sleep  = accept && (in_cmd == CMD_SLEEP);
    ctrl.halt   = accept && (in_cmd == CMD_HALT);
    ctrl.rotate = accept && (in_cmd == CMD_ROTATE);
    ctrl.level  = scan_level;
    ctrl.now    = (state == ST_SCAN) ? now_q : in_now;
    ctrl.period = in_period;
    ctrl.scheme = scheme_sel;
  end

  // Row of task cells linked by the search token.
  assign token[0] = 1'b1;

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    assign sel_vec[g] = (current_index == IDX_W'(g));

    ptd_cell #(
      .IDX  (g),
      .LAST (g == NUM_TASKS - 1)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .sel          (sel_vec[g]),
      .search_in    (token[g]),
      .search_out   (token[g+1]),
      .found        (found_vec[g]),
      .restart_flag (restart_vec[g])
    );
  end

  // Encode the claimed task; at most one cell claims per scan cycle.
  always_comb begin
    found_task    = '0;
    found_restart = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (found_vec[i]) begin
        found_task    = found_task | TASK_W'(i);
        found_restart = found_restart | restart_vec[i];
      end
    end
    any_found = |found_vec;
    scan_done = any_found || (scan_level == LEVEL_W'(NUM_LEVELS));
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_cmd == CMD_DISPATCH) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scheme_number <= SCHEME_ONE;
      current_index <= '0;
      scan_level    <= LEVEL_W'(1);
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        scan_level <= LEVEL_W'(1);
        if (in_cmd == CMD_ROTATE) begin
          scheme_number <= (scheme_number == SCHEME_THREE) ? SCHEME_ONE
                                                           : scheme_number + 2'd1;
        end
      end else if (state == ST_SCAN) begin
        if (scan_done) begin
          current_index <= any_found ? found_task[IDX_W-1:0] : IDX_W'(NUM_TASKS - 1);
        end else begin
          scan_level <= scan_level + LEVEL_W'(1);
        end
      end

      // Output register.
      if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result capture and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q       <= in_now;
      res_disp    <= 1'b0;
      res_task    <= '0;
      res_restart <= 1'b0;
      res_applied <= (in_cmd == CMD_ROTATE) ? scheme_number : 2'd0;
    end else if ((state == ST_SCAN) && any_found) begin
      res_disp    <= 1'b1;
      res_task    <= found_task;
      res_restart <= found_restart;
    end
    if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, res_applied, res_restart, res_task, res_disp};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_first  <= SCHEME_FIRST_RST;
      scheme_second <= SCHEME_SECOND_RST;
      scheme_third  <= SCHEME_THIRD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCHEME_FIRST:  scheme_first  <= cfg_data;
        CFG_SCHEME_SECOND: scheme_second <= cfg_data;
        CFG_SCHEME_THIRD:  scheme_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  // At most one task is claimed in any scan cycle.
  a_single_claim: assert property (@(posedge clk) disable iff (rst)
    $onehot0(found_vec))
    else $error("more than one task claimed in a scan cycle");

  // The scan level stays within the levels that exist.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_level >= LEVEL_W'(1)) &&
                           (scan_level <= LEVEL_W'(NUM_LEVELS)))
    else $error("scan level out of range");

  // The scheme number never leaves one to three.
  a_scheme_number: assert property (@(posedge clk) disable iff (rst)
    scheme_number != 2'd0)
    else $error("scheme number is zero");

  // A command other than dispatch goes straight to the result stage.
  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_cmd != CMD_DISPATCH)) |=> (state == ST_EMIT))
    else $error("non-dispatch command did not go to the result stage");

  // A scan that claims a task ends in that cycle.
  a_claim_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && any_found) |=> (state == ST_EMIT))
    else $error("scan continued after a claim");

endmodule

### sim/dispatch_monitor.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dispatch_monitor: result predictor and comparator for the task dispatcher
// Watches the command, result and configuration ports. It keeps its own copy
// of the task table, works out the result of each accepted command, and
// compares every result transaction field by field with the oldest one due.
// ---------------------------------------------------------------------------
module dispatch_monitor #(
  parameter int NUM_TASKS  = ptd_pkg::NUM_TASKS_DEF,
  parameter int NUM_LEVELS = ptd_pkg::NUM_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [71:0]                  s_tdata,   // cmd[1:0], now[33:2], period[65:34]
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [7:0]                   m_tdata,   // dispatched[0], task_res[3:1],
                                                  // restart[4], scheme_applied[6:5]
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [ptd_pkg::SCHEME_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import ptd_pkg::*;

  // One result transaction, dispatched in the lowest bit.
  typedef struct packed {
    logic [1:0]        scheme_applied;
    logic              restart;
    logic [TASK_W-1:0] task_idx;
    logic              dispatched;
  } outcome_t;

  // Shadow copy of the task table and the scheme registers.
  task_status_t        task_state   [NUM_TASKS];
  logic [LEVEL_W-1:0]  task_prio    [NUM_TASKS];
  logic [TIME_W-1:0]   nap_start    [NUM_TASKS];
  logic [TIME_W-1:0]   nap_length   [NUM_TASKS];
  logic                restart_flag [NUM_TASKS];
  logic [TASK_W-1:0]   current_task;
  logic [1:0]          next_scheme;
  logic [SCHEME_W-1:0] scheme_reg   [3];

  // Results still owed by the block, oldest first.
  outcome_t due_results [$];

  // Apply one command to the shadow table and return the result it causes.
  function automatic outcome_t serve_command(cmd_t op, logic [TIME_W-1:0] now_ms,
                                             logic [TIME_W-1:0] nap_ms);
    outcome_t            res;
    logic                found;
    logic [TIME_W-1:0]   elapsed;
    logic [SCHEME_W-1:0] lv_pack;
    logic [1:0]          applied;
    int                  cur;
    int                  lv;
    int                  i;
    res   = '0;
    found = 1'b0;
    cur   = (current_task < NUM_TASKS) ? int'(current_task) : 0;
    case (op)
      CMD_DISPATCH: begin
        // Lowest level first, lowest index first; a task woken here waits.
        for (lv = 1; lv <= NUM_LEVELS && !found; lv++) begin
          for (i = 0; i < NUM_TASKS && !found; i++) begin
            if (int'(task_prio[i]) == lv) begin
              if (task_state[i] == TS_SLEEPING) begin
                elapsed = now_ms - nap_start[i];
                if (elapsed >= nap_length[i]) task_state[i] = TS_READY;
              end else if (task_state[i] == TS_READY) begin
                task_state[i]  = TS_RUNNING;
                res.dispatched = 1'b1;
                res.task_idx   = TASK_W'(i);
                res.restart    = restart_flag[i];
                found          = 1'b1;
              end
            end
          end
        end
        current_task = found ? res.task_idx : TASK_W'(NUM_TASKS - 1);
      end
      CMD_SLEEP: begin
        task_state[cur]   = TS_SLEEPING;
        nap_start[cur]    = now_ms;
        nap_length[cur]   = nap_ms;
        restart_flag[cur] = 1'b0;
      end
      CMD_HALT: begin
        task_state[cur]   = TS_HALTED;
        restart_flag[cur] = 1'b0;
      end
      default: begin
        case (next_scheme)
          SCHEME_ONE: lv_pack = scheme_reg[CFG_SCHEME_FIRST];
          SCHEME_TWO: lv_pack = scheme_reg[CFG_SCHEME_SECOND];
          default:    lv_pack = scheme_reg[CFG_SCHEME_THIRD];
        endcase
        // Every task but the last becomes ready and restartable.
        for (i = 0; i < NUM_TASKS - 1; i++) begin
          if (i < SCHEME_TASKS) task_prio[i] = lv_pack[LEVEL_W*i +: LEVEL_W];
          task_state[i]   = TS_READY;
          restart_flag[i] = 1'b1;
        end
        applied            = (next_scheme == 2'd0) ? SCHEME_THREE : next_scheme;
        res.scheme_applied = applied;
        next_scheme        = (applied == SCHEME_THREE) ? SCHEME_ONE : applied + 2'd1;
      end
    endcase
    return res;
  endfunction

  // Track configuration writes, predict on commands, compare on results.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_state[i]   = TS_READY;
        task_prio[i]    = (i < 4) ? LEVEL_W'(i + 2) : LEVEL_W'(1);
        nap_start[i]    = '0;
        nap_length[i]   = '0;
        restart_flag[i] = 1'b0;
      end
      current_task = '0;
      next_scheme  = SCHEME_ONE;
      scheme_reg[CFG_SCHEME_FIRST]  = SCHEME_FIRST_RST;
      scheme_reg[CFG_SCHEME_SECOND] = SCHEME_SECOND_RST;
      scheme_reg[CFG_SCHEME_THIRD]  = SCHEME_THIRD_RST;
      due_results.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCHEME_FIRST:  scheme_reg[CFG_SCHEME_FIRST]  = cfg_data;
          CFG_SCHEME_SECOND: scheme_reg[CFG_SCHEME_SECOND] = cfg_data;
          CFG_SCHEME_THIRD:  scheme_reg[CFG_SCHEME_THIRD]  = cfg_data;
          default: ;
        endcase
      end
      // A result always belongs to an earlier command, so it is taken first.
      if (m_tvalid && m_tready) begin
        got = m_tdata[6:0];
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: result %h arrived with no command outstanding", $realtime, got);
        end else begin
          want = due_results.pop_front();
          if (got.dispatched !== want.dispatched || got.task_idx !== want.task_idx ||
              got.restart !== want.restart ||
              got.scheme_applied !== want.scheme_applied) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%t: mismatch (expected/actual) dispatched %b/%b task %0d/%0d",
                     $realtime, want.dispatched, got.dispatched, want.task_idx,
                     got.task_idx);
              $display(" restart %b/%b scheme %0d/%0d", want.restart, got.restart,
                       want.scheme_applied, got.scheme_applied);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        due_results.push_back(serve_command(cmd_t'(s_tdata[1:0]), s_tdata[33:2],
                                            s_tdata[65:34]));
      pending = due_results.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: command stimulus and verdict for the priority task dispatcher
// Runs a directed command sequence, then six random phases under different
// scheme settings and stall patterns, and reports the monitor's outcome.
// ---------------------------------------------------------------------------
module testbench;
  import ptd_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [71:0]         s_tdata   = '0;   // cmd[1:0], now[33:2], period[65:34]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [7:0]          m_tdata;          // dispatched[0], task_res[3:1],
                                         // restart[4], scheme_applied[6:5]
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = CFG_SCHEME_FIRST;
  logic [SCHEME_W-1:0] cfg_data  = '0;

  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 8;
  int                  recv_idle_pct = 55;
  int                  items_sent    = 0;
  logic [TIME_W-1:0]   clock_ms      = '0;

  priority_task_dispatcher_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  dispatch_monitor u_monitor (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 12 ns clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Give up if the run hangs.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Offer one command and return at the falling edge after it is accepted.
  // Valid is left high on return; only the random idle gaps and drain lower it.
  task automatic send_cmd(input cmd_t op, input logic [TIME_W-1:0] now_ms,
                          input logic [TIME_W-1:0] nap_ms);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, nap_ms, now_ms, op};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off new commands until every result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Write all three scheme registers on consecutive cycles.
  task automatic load_schemes(input logic [SCHEME_W-1:0] first_val,
                              input logic [SCHEME_W-1:0] second_val,
                              input logic [SCHEME_W-1:0] third_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCHEME_FIRST;
    cfg_data  <= first_val;
    @(negedge clk);
    cfg_index <= CFG_SCHEME_SECOND;
    cfg_data  <= second_val;
    @(negedge clk);
    cfg_index <= CFG_SCHEME_THIRD;
    cfg_data  <= third_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly levels that a pass visits, now and then 0, 6 or 7.
  function automatic logic [SCHEME_W-1:0] random_scheme();
    logic [SCHEME_W-1:0] v;
    for (int f = 0; f < SCHEME_TASKS; f++)
      v[LEVEL_W*f +: LEVEL_W] = ($urandom_range(9) == 0) ? LEVEL_W'($urandom_range(7))
                                                         : LEVEL_W'($urandom_range(5, 1));
    return v;
  endfunction

  // One time slice: a dispatch, usually followed by the started task reporting back,
  // with an occasional rotate and some fully random commands as noise.
  task automatic run_slice();
    int                roll;
    logic [TIME_W-1:0] nap;
    roll = $urandom_range(99);
    if (roll < 10) begin
      send_cmd(cmd_t'($urandom_range(3)), $urandom, $urandom);
    end else if (roll < 18) begin
      send_cmd(CMD_ROTATE, clock_ms, $urandom);
    end else begin
      clock_ms += $urandom_range(50);
      send_cmd(CMD_DISPATCH, clock_ms, $urandom);
      clock_ms += $urandom_range(20);
      roll = $urandom_range(99);
      case ($urandom_range(19))
        0:       nap = '0;
        1:       nap = '1;
        2:       nap = $urandom;
        default: nap = $urandom_range(80);
      endcase
      if (roll < 70)
        send_cmd(CMD_SLEEP, clock_ms, nap);
      else if (roll < 76)
        send_cmd(CMD_HALT, clock_ms, $urandom);
    end
  endtask

  // Main stimulus.
  initial begin
    int target;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the reset schemes: wake on time wrap, zero and
    // maximum sleep, a pass that finds nothing, rotates through all schemes.
    send_cmd(CMD_DISPATCH, 32'h0000_0000, 32'h0000_0000);
    send_cmd(CMD_SLEEP,    32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_cmd(CMD_DISPATCH, 32'h0000_0010, 32'h0000_0000);
    send_cmd(CMD_HALT,     32'h0000_0020, 32'hFFFF_FFFF);
    send_cmd(CMD_DISPATCH, 32'h0000_0030, 32'h0000_0000);
    send_cmd(CMD_SLEEP,    32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(CMD_DISPATCH, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(CMD_DISPATCH, 32'h0000_0001, 32'h0000_0000);
    send_cmd(CMD_DISPATCH, 32'h0000_0002, 32'h0000_0000);
    send_cmd(CMD_DISPATCH, 32'h0000_0003, 32'h0000_0000);
    send_cmd(CMD_SLEEP,    32'h0000_0000, 32'h7FFF_FFFF);
    send_cmd(CMD_DISPATCH, 32'h7FFF_FFFE, 32'h0000_0000);
    send_cmd(CMD_ROTATE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_DISPATCH, 32'h8000_0000, 32'h0000_0000);
    send_cmd(CMD_DISPATCH, 32'h8000_0001, 32'h0000_0000);
    send_cmd(CMD_ROTATE,   32'h0000_0000, 32'h0000_0000);
    send_cmd(CMD_DISPATCH, 32'h8000_0002, 32'h0000_0000);
    send_cmd(CMD_ROTATE,   32'h5555_5555, 32'hAAAA_AAAA);
    send_cmd(CMD_ROTATE,   32'hAAAA_AAAA, 32'h5555_5555);
    send_cmd(CMD_HALT,     32'h8000_0003, 32'h0000_0000);
    send_cmd(CMD_DISPATCH, 32'h8000_0004, 32'h0000_0000);
    send_cmd(CMD_SLEEP,    32'hAAAA_AAAA, 32'h5555_5555);
    send_cmd(CMD_DISPATCH, 32'hFFFF_FFFF, 32'h0000_0000);

    // Random phases, each under its own schemes; phases share stall patterns in pairs.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0:       load_schemes(12'h000, 12'hFFF, 12'o2121);
        2:       load_schemes(SCHEME_FIRST_RST, SCHEME_SECOND_RST, SCHEME_THIRD_RST);
        3:       load_schemes(SCHEME_W'($urandom_range(4095)),
                              SCHEME_W'($urandom_range(4095)),
                              SCHEME_W'($urandom_range(4095)));
        default: load_schemes(random_scheme(), random_scheme(), random_scheme());
      endcase
      send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 55 : 0;
      recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 8 : 0;
      clock_ms      = (ph == 3) ? 32'hFFFF_F000 : $urandom;
      target        = items_sent + 320;
      while (items_sent < target) begin
        // Halfway through, let the block run completely dry.
        if (items_sent >= target - 160 && items_sent < target - 157) drain();
        run_slice();
      end
    end

    drain();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

### priority_task_dispatcher_core.f
rtl/ptd_pkg.sv
rtl/ptd_cell.sv
rtl/priority_task_dispatcher_core.sv
sim/dispatch_monitor.sv
sim/testbench.sv
